@@ src/arm_pkg.sv @@
// Shared types, constants and the arctangent table for the axis rotation matrix block.
// No dependencies; imported by every module of the block.
`default_nettype none

package arm_pkg;

    // CORDIC configuration. The arctangent table has 24 entries, so the chain is capped there.
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int STAGE_W       = $clog2(TABLE_LEN);

    // Field widths.
    localparam int DELTA_W = 26;
    localparam int ANGLE_W = 25;
    localparam int ENTRY_W = 16;
    localparam int XY_W    = 33;
    localparam int Z_W     = 33;
    localparam int ACC_W   = 27;

    // Angle constants in degrees with 16 fractional bits.
    localparam logic signed [ACC_W-1:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [ACC_W-1:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [ACC_W-1:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [DELTA_W-1:0] DELTA_LIMIT = 26'sd23592959;

    // Inverse CORDIC gain in Q30 and unity in Q1.14.
    localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
    localparam int ONE_Q14 = 16384;

    // Axis register codes; any other code selects the z axis.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // One word in flight through the CORDIC chain.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
        logic [ANGLE_W-1:0]     angle;
    } cordic_t;

    // round(atan(2^-i) * 180/pi * 2^24).
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [STAGE_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 33'sd754974720;
            5'd1:    v = 33'sd445687602;
            5'd2:    v = 33'sd235489089;
            5'd3:    v = 33'sd119537938;
            5'd4:    v = 33'sd60000934;
            5'd5:    v = 33'sd30029717;
            5'd6:    v = 33'sd15018523;
            5'd7:    v = 33'sd7509720;
            5'd8:    v = 33'sd3754917;
            5'd9:    v = 33'sd1877466;
            5'd10:   v = 33'sd938734;
            5'd11:   v = 33'sd469367;
            5'd12:   v = 33'sd234684;
            5'd13:   v = 33'sd117342;
            5'd14:   v = 33'sd58671;
            5'd15:   v = 33'sd29335;
            5'd16:   v = 33'sd14668;
            5'd17:   v = 33'sd7334;
            5'd18:   v = 33'sd3667;
            5'd19:   v = 33'sd1833;
            5'd20:   v = 33'sd917;
            5'd21:   v = 33'sd458;
            5'd22:   v = 33'sd229;
            5'd23:   v = 33'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/arm_front.sv @@
// Angle accumulator and quadrant fold ahead of the CORDIC chain.
// Depends on arm_pkg.
`default_nettype none

module arm_front
    import arm_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [DELTA_W-1:0] s_delta_angle,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output cordic_t                        out_data
);

    logic [ANGLE_W-1:0]      acc_reg;
    logic [ANGLE_W-1:0]      acc_next;
    logic                    a_valid_reg;
    logic                    b_valid_reg;
    cordic_t                 b_data_reg;
    cordic_t                 b_data_next;
    logic                    a_ready;
    logic                    b_ready;
    logic signed [DELTA_W-1:0] d_sat;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] a_fold;
    logic signed [ACC_W-1:0] a_half;
    logic                    neg;

    assign b_ready = !b_valid_reg || out_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    // Clamp the increment, then accumulate and wrap with one add or subtract of a full turn.
    always_comb begin
        if (s_delta_angle > DELTA_LIMIT) begin
            d_sat = DELTA_LIMIT;
        end else if (s_delta_angle < -DELTA_LIMIT) begin
            d_sat = -DELTA_LIMIT;
        end else begin
            d_sat = s_delta_angle;
        end
        sum = $signed({2'b00, acc_reg}) + ACC_W'(d_sat);
        if (sum >= FULL_TURN) begin
            acc_next = ANGLE_W'(sum - FULL_TURN);
        end else if (sum < 0) begin
            acc_next = ANGLE_W'(sum + FULL_TURN);
        end else begin
            acc_next = ANGLE_W'(sum);
        end
    end

    // Stage A holds its angle in the accumulator itself: the accumulator only moves
    // on an accept, and an accept only happens while stage A is free to move on.
    always_comb begin
        a_half = $signed({2'b00, acc_reg});
        if (a_half >= HALF_TURN) begin
            a_half = a_half - FULL_TURN;
        end
        neg = 1'b0;
        a_fold = a_half;
        if (a_half > QUARTER_TURN) begin
            a_fold = a_half - HALF_TURN;
            neg = 1'b1;
        end else if (a_half < -QUARTER_TURN) begin
            a_fold = a_half + HALF_TURN;
            neg = 1'b1;
        end
        b_data_next.x     = INV_GAIN_Q30;
        b_data_next.y     = '0;
        b_data_next.z     = Z_W'(a_fold) <<< 8;
        b_data_next.neg   = neg;
        b_data_next.angle = acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (s_valid && a_ready) begin
                acc_reg <= acc_next;
            end
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

`ifndef ASSERT_OFF
    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $signed({2'b00, acc_reg}) < FULL_TURN)
        else $error("accumulated angle left the [0,360) range");
    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_data_reg.z <= (Z_W'(QUARTER_TURN) <<< 8))
                     && (b_data_reg.z >= -(Z_W'(QUARTER_TURN) <<< 8)))
        else $error("folded angle outside [-90,90] degrees");
    a_acc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && a_ready) |=> $stable(acc_reg))
        else $error("accumulator moved without an accepted word");
`endif

endmodule

`default_nettype wire

@@ src/arm_cell.sv @@
// One CORDIC rotation-mode iteration with its own pipeline register.
// Depends on arm_pkg.
`default_nettype none

module arm_cell
    import arm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [STAGE_W-1:0] shift,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cordic_t            in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cordic_t                 out_data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  step;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        dx   = in_data.y >>> shift;
        dy   = in_data.x >>> shift;
        step = atan_q24(shift);
        data_next = in_data;
        if (!in_data.z[Z_W-1]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - step;
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ src/arm_back.sv @@
// Output stage: sign restore, rounding to Q1.14 with saturation, matrix assembly.
// Depends on arm_pkg.
`default_nettype none

module arm_back
    import arm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [1:0]         axis,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cordic_t            in_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [ANGLE_W-1:0]      m_angle_now,
    output logic signed [ENTRY_W-1:0] m_m00,
    output logic signed [ENTRY_W-1:0] m_m01,
    output logic signed [ENTRY_W-1:0] m_m02,
    output logic signed [ENTRY_W-1:0] m_m10,
    output logic signed [ENTRY_W-1:0] m_m11,
    output logic signed [ENTRY_W-1:0] m_m12,
    output logic signed [ENTRY_W-1:0] m_m20,
    output logic signed [ENTRY_W-1:0] m_m21,
    output logic signed [ENTRY_W-1:0] m_m22
);

    localparam int R_W = XY_W - 15;
    localparam logic signed [ENTRY_W-1:0] ONE  = ENTRY_W'(ONE_Q14);
    localparam logic signed [ENTRY_W-1:0] ZERO = '0;

    typedef logic signed [ENTRY_W-1:0] entry_t;

    function automatic entry_t to_q14(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0] t;
        logic signed [R_W-1:0] r;
        entry_t res;
        t = {v[XY_W-1], v} + (XY_W+1)'(32768);
        r = t[XY_W:16];
        if (r > R_W'(ONE_Q14)) begin
            res = ONE;
        end else if (r < -R_W'(ONE_Q14)) begin
            res = -ONE;
        end else begin
            res = ENTRY_W'(r);
        end
        return res;
    endfunction

    logic   valid_reg;
    logic signed [XY_W-1:0] xc;
    logic signed [XY_W-1:0] ys;
    entry_t c;
    entry_t s;
    entry_t m_next [9];
    entry_t m_reg  [9];
    logic [ANGLE_W-1:0] angle_reg;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        xc = in_data.neg ? -in_data.x : in_data.x;
        ys = in_data.neg ? -in_data.y : in_data.y;
        c  = to_q14(xc);
        s  = to_q14(ys);
        case (axis)
            AXIS_X: begin
                m_next = '{ONE, ZERO, ZERO, ZERO, c, -s, ZERO, s, c};
            end
            AXIS_Y: begin
                m_next = '{c, ZERO, s, ZERO, ONE, ZERO, -s, ZERO, c};
            end
            default: begin
                m_next = '{c, -s, ZERO, s, c, ZERO, ZERO, ZERO, ONE};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            m_reg     <= m_next;
            angle_reg <= in_data.angle;
        end
    end

    assign m_valid     = valid_reg;
    assign m_angle_now = angle_reg;
    assign m_m00 = m_reg[0];
    assign m_m01 = m_reg[1];
    assign m_m02 = m_reg[2];
    assign m_m10 = m_reg[3];
    assign m_m11 = m_reg[4];
    assign m_m12 = m_reg[5];
    assign m_m20 = m_reg[6];
    assign m_m21 = m_reg[7];
    assign m_m22 = m_reg[8];

endmodule

`default_nettype wire

@@ src/axis_rotation_matrix.sv @@
// Top level of the elementary 3x3 rotation matrix generator.
// Depends on arm_pkg, arm_front, arm_cell and arm_back.
//
// Each input word carries a signed angle increment in degrees with 16 fractional
// bits; increments beyond +/-(360 - 2^-16) degrees are clamped. The block adds it
// to an internal angle, wraps the sum into [0,360) and returns one result word
// with the wrapped angle and the nine Q1.14 entries of the rotation matrix about
// the axis held in the configuration register (0 x, 1 y, 2 or 3 z). The angle
// resets to zero and the axis to x. One word is accepted per clock cycle
// sustained while the result side does not stall; the only loop is the angle
// accumulator. From accept to result valid, the accumulator loads at the
// accepting edge, then the word passes the quadrant fold register, one register
// per CORDIC cell (16 CORDIC stages) and the output register. Every stage
// carries its own valid bit and only stalls when the stage after it is full, so
// back-pressure on the result side fills bubbles first. The axis register should
// only be written while no word is in flight; cfg_ready is always high.
`default_nettype none

module axis_rotation_matrix
    import arm_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [DELTA_W-1:0] s_delta_angle,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [ANGLE_W-1:0]             m_angle_now,
    output logic signed [ENTRY_W-1:0]      m_m00,
    output logic signed [ENTRY_W-1:0]      m_m01,
    output logic signed [ENTRY_W-1:0]      m_m02,
    output logic signed [ENTRY_W-1:0]      m_m10,
    output logic signed [ENTRY_W-1:0]      m_m11,
    output logic signed [ENTRY_W-1:0]      m_m12,
    output logic signed [ENTRY_W-1:0]      m_m20,
    output logic signed [ENTRY_W-1:0]      m_m21,
    output logic signed [ENTRY_W-1:0]      m_m22
);

    // Axis register. Writes are always accepted.
    logic [1:0] axis_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= AXIS_X;
        end else if (cfg_valid) begin
            axis_reg <= cfg_data;
        end
    end

    // Handshake chain: index k is the input of cell k, index NUM_CELLS feeds the output stage.
    cordic_t chain_data  [NUM_CELLS+1];
    logic    chain_valid [NUM_CELLS+1];
    logic    chain_ready [NUM_CELLS+1];

    // The front end accumulates the angle and folds it into [-90,90] degrees,
    // remembering whether sine and cosine must be negated afterwards.
    arm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_delta_angle (s_delta_angle),
        .out_valid     (chain_valid[0]),
        .out_ready     (chain_ready[0]),
        .out_data      (chain_data[0])
    );

    // One cell per CORDIC iteration; each cell shifts by its own position in the row.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        arm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (STAGE_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // The output stage restores signs, rounds, saturates and places sine and cosine in the matrix.
    arm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .axis        (axis_reg),
        .in_valid    (chain_valid[NUM_CELLS]),
        .in_ready    (chain_ready[NUM_CELLS]),
        .in_data     (chain_data[NUM_CELLS]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_angle_now (m_angle_now),
        .m_m00       (m_m00),
        .m_m01       (m_m01),
        .m_m02       (m_m02),
        .m_m10       (m_m10),
        .m_m11       (m_m11),
        .m_m12       (m_m12),
        .m_m20       (m_m20),
        .m_m21       (m_m21),
        .m_m22       (m_m22)
    );

`ifndef ASSERT_OFF
    a_out_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed({2'b00, m_angle_now}) < FULL_TURN))
        else $error("result angle outside [0,360)");
    a_x_axis_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && axis_reg == AXIS_X) |->
            (m_m00 == ENTRY_W'(ONE_Q14)) && (m_m01 == '0) && (m_m10 == '0))
        else $error("x-axis matrix has wrong fixed entries");
    a_z_skew: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && axis_reg != AXIS_X && axis_reg != AXIS_Y) |->
            (m_m01 == -m_m10) && (m_m00 == m_m11))
        else $error("z-axis matrix lost its rotation symmetry");
    a_entry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_m11 <= ENTRY_W'(ONE_Q14)) && (m_m11 >= -ENTRY_W'(ONE_Q14))
                 && (m_m22 <= ENTRY_W'(ONE_Q14)) && (m_m22 >= -ENTRY_W'(ONE_Q14)))
        else $error("matrix entry outside the Q1.14 unit range");
`endif

endmodule

`default_nettype wire
